@@ rtl/core/dxt5_pkg.sv @@
// Shared types, constants and arithmetic helpers for the DXT5 block decoder.
// Depends on nothing; every module of the decoder imports it.

package dxt5_pkg;

  localparam int MaxImageEdge      = 4096;
  localparam int QueueDepthDefault = 2;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;
  localparam int CoordW   = 12;

  localparam logic [CfgDataW-1:0] ImageEdgeReset = 13'd4096;
  localparam logic [7:0]          AlphaOpaque    = 8'd255;
  localparam logic [7:0]          AlphaClear     = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1
  } cfg_reg_e;

  // Image bounds as written through the configuration port.
  typedef struct packed {
    logic [CfgDataW-1:0] width;
    logic [CfgDataW-1:0] height;
  } bounds_t;

  // One decoded block as it travels from the front end to the back end.
  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [15:0]       mask;
    logic [47:0]       alpha_idx;
    logic [31:0]       colour_idx;
    logic [7:0][7:0]   alpha_pal;
    logic [3:0][7:0]   red_pal;
    logic [3:0][7:0]   green_pal;
    logic [3:0][7:0]   blue_pal;
  } blk_t;

  // Truncating v*255/31, written as 8v + floor(7v/31).
  function automatic logic [7:0] widen5(logic [4:0] v);
    logic [2:0] f;
    f = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
      + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
    return {v, 3'b000} + {5'b00000, f};
  endfunction

  // Truncating v*255/63, written as 4v + floor(v/21).
  function automatic logic [7:0] widen6(logic [5:0] v);
    logic [1:0] f;
    f = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
    return {v, 2'b00} + {6'b000000, f};
  endfunction

  // Reciprocal multiplications; exact floors over the ranges the palettes produce.
  function automatic logic [7:0] div3(logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div7(logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

endpackage

@@ rtl/core/dxt5_front.sv @@
// Front end of the DXT5 decoder: input register, endpoint and weighted-sum stage,
// and palette division feeding the block queue. Depends on dxt5_pkg.

module dxt5_front import dxt5_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bounds_t             bounds_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [63:0]         alpha_half_i,
  input  logic [63:0]         colour_half_i,
  input  logic [CoordW-1:0]   block_left_i,
  input  logic [CoordW-1:0]   block_top_i,
  output logic                q_push_o,
  output blk_t                q_wdata_o,
  input  logic                q_full_i
);

  // Stage A: raw block.
  logic              a_valid_q, a_valid_d;
  logic [63:0]       a_alpha_q, a_colour_q;
  logic [CoordW-1:0] a_left_q, a_top_q;

  // Stage B: widened endpoints, weighted sums and the in-bounds mask.
  logic                  b_valid_q, b_valid_d;
  logic [CoordW-1:0]     b_left_q, b_top_q;
  logic [15:0]           b_mask_q;
  logic [47:0]           b_aidx_q;
  logic [31:0]           b_cidx_q;
  logic [7:0]            b_a0_q, b_a1_q;
  logic                  b_mode7_q;
  logic [5:0][10:0]      b_asum_q;
  logic [2:0][1:0][7:0]  b_ep_q;
  logic [2:0][1:0][9:0]  b_cs_q;

  logic                  ready_a, ready_b;
  logic                  load_a, load_b;

  logic [15:0]           mask_d;
  logic [3:0]            col_ok, row_ok;
  logic [CfgDataW-1:0]   col_pos, row_pos;
  logic [7:0]            a0, a1;
  logic                  mode7;
  logic [5:0][10:0]      asum_d;
  logic [2:0][1:0][7:0]  ep_d;
  logic [2:0][1:0][9:0]  cs_d;
  logic [15:0]           c0, c1;

  assign ready_b    = !b_valid_q || !q_full_i;
  assign ready_a    = !a_valid_q || ready_b;
  assign in_stall_o = !ready_a;
  assign load_a     = in_valid_i && ready_a;
  assign load_b     = a_valid_q && ready_b;

  always_comb begin
    a_valid_d = ready_a ? in_valid_i : a_valid_q;
    b_valid_d = ready_b ? a_valid_q : b_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      a_alpha_q  <= alpha_half_i;
      a_colour_q <= colour_half_i;
      a_left_q   <= block_left_i;
      a_top_q    <= block_top_i;
    end
  end

  // Stage A to B logic.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      col_pos   = {1'b0, a_left_q} + CfgDataW'(j);
      row_pos   = {1'b0, a_top_q} + CfgDataW'(j);
      col_ok[j] = (col_pos < bounds_i.width) && (32'(col_pos) < 32'(MaxImageEdge));
      row_ok[j] = (row_pos < bounds_i.height) && (32'(row_pos) < 32'(MaxImageEdge));
    end
    for (int k = 0; k < 16; k++) begin
      mask_d[k] = row_ok[k / 4] && col_ok[k % 4];
    end

    a0    = a_alpha_q[7:0];
    a1    = a_alpha_q[15:8];
    mode7 = a0 > a1;
    for (int c = 2; c < 8; c++) begin
      if (mode7) begin
        asum_d[c-2] = 11'(8 - c) * {3'b000, a0} + 11'(c - 1) * {3'b000, a1};
      end else if (c < 6) begin
        asum_d[c-2] = 11'(6 - c) * {3'b000, a0} + 11'(c - 1) * {3'b000, a1};
      end else begin
        asum_d[c-2] = '0;
      end
    end

    c0 = a_colour_q[15:0];
    c1 = a_colour_q[31:16];
    ep_d[0][0] = widen5(c0[15:11]);
    ep_d[0][1] = widen5(c1[15:11]);
    ep_d[1][0] = widen6(c0[10:5]);
    ep_d[1][1] = widen6(c1[10:5]);
    ep_d[2][0] = widen5(c0[4:0]);
    ep_d[2][1] = widen5(c1[4:0]);
    for (int ch = 0; ch < 3; ch++) begin
      cs_d[ch][0] = {1'b0, ep_d[ch][0], 1'b0} + {2'b00, ep_d[ch][1]};
      cs_d[ch][1] = {2'b00, ep_d[ch][0]} + {1'b0, ep_d[ch][1], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      b_left_q  <= a_left_q;
      b_top_q   <= a_top_q;
      b_mask_q  <= mask_d;
      b_aidx_q  <= a_alpha_q[63:16];
      b_cidx_q  <= a_colour_q[63:32];
      b_a0_q    <= a0;
      b_a1_q    <= a1;
      b_mode7_q <= mode7;
      b_asum_q  <= asum_d;
      b_ep_q    <= ep_d;
      b_cs_q    <= cs_d;
    end
  end

  // Stage B to queue: palette divisions.
  always_comb begin
    q_wdata_o            = '0;
    q_wdata_o.left       = b_left_q;
    q_wdata_o.top        = b_top_q;
    q_wdata_o.mask       = b_mask_q;
    q_wdata_o.alpha_idx  = b_aidx_q;
    q_wdata_o.colour_idx = b_cidx_q;
    q_wdata_o.alpha_pal[0] = b_a0_q;
    q_wdata_o.alpha_pal[1] = b_a1_q;
    for (int c = 2; c < 8; c++) begin
      if (b_mode7_q) begin
        q_wdata_o.alpha_pal[c] = div7(b_asum_q[c-2]);
      end else if (c == 6) begin
        q_wdata_o.alpha_pal[c] = AlphaClear;
      end else if (c == 7) begin
        q_wdata_o.alpha_pal[c] = AlphaOpaque;
      end else begin
        q_wdata_o.alpha_pal[c] = div5(b_asum_q[c-2]);
      end
    end
    q_wdata_o.red_pal   = {div3(b_cs_q[0][1]), div3(b_cs_q[0][0]), b_ep_q[0][1], b_ep_q[0][0]};
    q_wdata_o.green_pal = {div3(b_cs_q[1][1]), div3(b_cs_q[1][0]), b_ep_q[1][1], b_ep_q[1][0]};
    q_wdata_o.blue_pal  = {div3(b_cs_q[2][1]), div3(b_cs_q[2][0]), b_ep_q[2][1], b_ep_q[2][0]};
  end

  assign q_push_o = b_valid_q && !q_full_i;

endmodule

@@ rtl/core/dxt5_queue.sv @@
// Short register queue of decoded blocks between the decoder's front and back ends.
// Depends on dxt5_pkg for the block record type.

module dxt5_queue import dxt5_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  blk_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output blk_t rdata_o,
  output logic empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  blk_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue count exceeds its depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule

@@ rtl/core/dxt5_back.sv @@
// Back end of the DXT5 decoder: walks the in-bounds pixels of the block at the
// queue head, one per cycle while the output is not stalled, into the output register. Depends on dxt5_pkg.

module dxt5_back import dxt5_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  blk_t              head_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CoordW-1:0] pixel_col_o,
  output logic [CoordW-1:0] pixel_row_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [7:0]        opacity_o,
  output logic              final_pixel_o
);

  logic              fresh_q, fresh_d;
  logic [15:0]       rem_q, rem_d;
  logic              out_valid_q, out_valid_d;
  logic [CoordW-1:0] col_q, row_q;
  logic [7:0]        red_q, green_q, blue_q, alpha_q;
  logic              final_q;

  logic [15:0]       cur;
  logic [15:0]       pick_bit;
  logic [15:0]       rest;
  logic [3:0]        pick;
  logic              out_free;
  logic              emit;
  logic [2:0]        acode;
  logic [1:0]        ccode;

  // A block's mask is taken straight from the queue head on its first cycle, so
  // consecutive blocks follow each other without a gap.
  assign cur      = fresh_q ? head_i.mask : rem_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    pick = '0;
    for (int k = 15; k >= 0; k--) begin
      if (cur[k]) begin
        pick = 4'(k);
      end
    end
    pick_bit = 16'b1 << pick;
    rest     = cur & ~pick_bit;
    acode    = head_i.alpha_idx[3*pick +: 3];
    ccode    = head_i.colour_idx[2*pick +: 2];
  end

  always_comb begin
    emit        = 1'b0;
    q_pop_o     = 1'b0;
    fresh_d     = fresh_q;
    rem_d       = rem_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    if (!q_empty_i) begin
      if (cur == '0) begin
        q_pop_o = 1'b1;
        fresh_d = 1'b1;
      end else if (out_free) begin
        emit        = 1'b1;
        out_valid_d = 1'b1;
        if (rest == '0) begin
          q_pop_o = 1'b1;
          fresh_d = 1'b1;
        end else begin
          fresh_d = 1'b0;
          rem_d   = rest;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b1;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fresh_q     <= fresh_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      col_q   <= head_i.left + {{(CoordW-2){1'b0}}, pick[1:0]};
      row_q   <= head_i.top + {{(CoordW-2){1'b0}}, pick[3:2]};
      red_q   <= head_i.red_pal[ccode];
      green_q <= head_i.green_pal[ccode];
      blue_q  <= head_i.blue_pal[ccode];
      alpha_q <= head_i.alpha_pal[acode];
      final_q <= rest == '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_col_o   = col_q;
  assign pixel_row_o   = row_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign opacity_o     = alpha_q;
  assign final_pixel_o = final_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !fresh_q |-> rem_q != '0)
    else $error("block in progress with no pixels left");
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |-> $onehot(pick_bit & cur))
    else $error("emitted pixel is not pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (emit && rest == '0) |-> q_pop_o)
    else $error("last pixel of a block did not release the queue entry");

endmodule

@@ rtl/core/dxt5_block_decoder_core.sv @@
// Top level of the DXT5 (BC3) block decoder: configuration registers and the
// front end, block queue and back end. Depends on dxt5_pkg and its submodules.

// Each accepted 16-byte block yields its in-bounds pixels in row order, one per
// cycle while the output is not stalled, with the last one flagged by
// final_pixel_o. The back end's pixel walker sets the sustained rate: it takes up
// the next block only once the visible pixels of the last one are out, and it
// releases a block that lies wholly outside the image without emitting a pixel.
// On its way to the first pixel a block passes the input register, sum stage,
// queue and output register. The queue holds QUEUE_DEPTH decoded blocks, so
// input keeps flowing while the output stalls, until the queue fills.
// Write image_width and image_height only while the decoder is idle.

module dxt5_block_decoder_core import dxt5_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [63:0]         alpha_half_i,
  input  logic [63:0]         colour_half_i,
  input  logic [CoordW-1:0]   block_left_i,
  input  logic [CoordW-1:0]   block_top_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CoordW-1:0]   pixel_col_o,
  output logic [CoordW-1:0]   pixel_row_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          opacity_o,
  output logic                final_pixel_o
);

  bounds_t bounds_q, bounds_d;
  logic    q_push, q_full, q_pop, q_empty;
  blk_t    q_wdata, q_rdata;

  always_comb begin
    bounds_d = bounds_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegImageWidth:  bounds_d.width  = cfg_wdata_i;
        RegImageHeight: bounds_d.height = cfg_wdata_i;
        default:        bounds_d = bounds_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.width  <= ImageEdgeReset;
      bounds_q.height <= ImageEdgeReset;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  dxt5_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bounds_i      (bounds_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .alpha_half_i  (alpha_half_i),
    .colour_half_i (colour_half_i),
    .block_left_i  (block_left_i),
    .block_top_i   (block_top_i),
    .q_push_o      (q_push),
    .q_wdata_o     (q_wdata),
    .q_full_i      (q_full)
  );

  dxt5_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  dxt5_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_rdata),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_col_o   (pixel_col_o),
    .pixel_row_o   (pixel_row_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .opacity_o     (opacity_o),
    .final_pixel_o (final_pixel_o)
  );

endmodule
